@@ src/button_debounce_long_press_assert.svh @@
// ----------------------------------------------------------------------------
// Button debounce with long press: assertion macros
// Concurrent check helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define BDLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdlp assertion failed");

// next-cycle implication
`define BDLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdlp assertion failed");

`endif

@@ src/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press: package
// Word types, operation and mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned LongW    = 16;
  localparam int unsigned DebW     = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [1:0] OP_SAMPLE     = 2'd0;
  localparam logic [1:0] OP_READ_PRESS = 2'd1;
  localparam logic [1:0] OP_READ_LONG  = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_DEBOUNCE = 3'd1;
  localparam logic [2:0] MODE_PRESSED  = 3'd2;
  localparam logic [2:0] MODE_RELEASED = 3'd3;
  localparam logic [2:0] MODE_LONG     = 3'd4;

  localparam logic CFG_LONG_PRESS = 1'b0;
  localparam logic CFG_DEBOUNCE   = 1'b1;

  localparam logic [LongW-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [DebW-1:0]  DEBOUNCE_RST   = 8'd10;

  typedef struct packed {
    logic [1:0]       operation;
    logic             button_down;
    logic [TimeW-1:0] now_ms;
  } bdlp_in_t;

  typedef struct packed {
    logic pressed_level;
    logic flag_read;
  } bdlp_out_t;

  typedef struct packed {
    logic [LongW-1:0] long_press_ms;
    logic [DebW-1:0]  debounce_ms;
  } bdlp_cfg_t;

endpackage

@@ src/bdlp_cfg.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press: configuration registers
// Hold time and settle time, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_cfg import bdlp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output bdlp_cfg_t           cfg_o
);

  bdlp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_PRESS: cfg_d.long_press_ms = cfg_wdata_i[LongW-1:0];
        CFG_DEBOUNCE:   cfg_d.debounce_ms   = cfg_wdata_i[DebW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= LONG_PRESS_RST;
      cfg_q.debounce_ms   <= DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/bdlp_fsm.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press: state machine
// Mode, change time, debounced level and sticky flags; one word per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_fsm import bdlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  bdlp_in_t  word_i,
  input  bdlp_cfg_t cfg_i,
  output bdlp_out_t res_o
);

  logic [2:0]       mode_q, mode_d;
  logic [TimeW-1:0] last_q, last_d;
  logic             level_q, level_d;
  logic             press_q, press_d;
  logic             long_q, long_d;
  logic             taken;
  logic [TimeW-1:0] elapsed;
  logic             deb_done, long_done;

  assign elapsed   = word_i.now_ms - last_q;
  assign deb_done  = elapsed >= {{(TimeW-DebW){1'b0}}, cfg_i.debounce_ms};
  assign long_done = elapsed >= {{(TimeW-LongW){1'b0}}, cfg_i.long_press_ms};

  always_comb begin
    mode_d  = mode_q;
    last_d  = last_q;
    level_d = level_q;
    press_d = press_q;
    long_d  = long_q;
    taken   = 1'b0;
    unique case (word_i.operation)
      OP_SAMPLE: begin
        unique case (mode_q)
          MODE_IDLE: begin
            if (word_i.button_down) begin
              mode_d = MODE_DEBOUNCE;
              last_d = word_i.now_ms;
            end
          end
          MODE_DEBOUNCE: begin
            if (deb_done) begin
              if (word_i.button_down) begin
                mode_d  = MODE_PRESSED;
                last_d  = word_i.now_ms;
                level_d = 1'b1;
                press_d = 1'b1;
              end else begin
                mode_d = MODE_IDLE;
              end
            end
          end
          MODE_PRESSED: begin
            priority if (!word_i.button_down) begin
              mode_d = MODE_RELEASED;
              last_d = word_i.now_ms;
            end else if (long_done) begin
              mode_d = MODE_LONG;
              last_d = word_i.now_ms;
              long_d = 1'b1;
            end
          end
          MODE_RELEASED: begin
            if (deb_done) begin
              if (!word_i.button_down) begin
                mode_d  = MODE_IDLE;
                level_d = 1'b0;
              end else begin
                mode_d = MODE_DEBOUNCE;
                last_d = word_i.now_ms;
              end
            end
          end
          MODE_LONG: begin
            if (!word_i.button_down) begin
              mode_d  = MODE_RELEASED;
              last_d  = word_i.now_ms;
              level_d = 1'b0;
            end
          end
          default: mode_d = MODE_IDLE;
        endcase
      end
      OP_READ_PRESS: begin
        taken   = press_q;
        press_d = 1'b0;
      end
      OP_READ_LONG: begin
        taken = long_q;
        if (long_q) begin
          press_d = 1'b0;
          long_d  = 1'b0;
        end
      end
      OP_CLEAR: begin
        press_d = 1'b0;
        long_d  = 1'b0;
      end
      default: taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      last_q  <= '0;
      level_q <= 1'b0;
      press_q <= 1'b0;
      long_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      last_q  <= last_d;
      level_q <= level_d;
      press_q <= press_d;
      long_q  <= long_d;
    end
  end

  assign res_o.pressed_level = level_d;
  assign res_o.flag_read     = taken;

endmodule

@@ src/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press: top level
// Input register, state machine step and result register.
// ----------------------------------------------------------------------------
// Use: each input word is a sample (level and millisecond stamp) or a flag
// access (read-clear press, read-clear long press, clear both). Every word
// gives exactly one result word: debounced level and the flag read.
// Channels use valid/stall; a word moves when valid is high and stall low.
// A word passes the input register, then the state step into the result
// register; the step waits while the result register is full and stalled.
// The block takes one word per cycle unless both registers are full and
// out_stall_i is high; the state step is a 32-bit subtract and compare plus
// a mux, all combinational.
// A stalled result holds; the input register still fills behind it, and
// in_stall_o rises only when both registers are full and out_stall_i is high.
// Reset: mode idle, change time zero, level and flags clear, hold time 1000,
// settle time 10; both registers empty.
// The user must write configuration only while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press import bdlp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_vld_i,
  output logic                in_stall_o,
  input  bdlp_in_t            in_data_i,
  output logic                out_vld_o,
  input  logic                out_stall_i,
  output bdlp_out_t           out_data_o
);

  `include "button_debounce_long_press_assert.svh"

  bdlp_cfg_t cfg;
  bdlp_in_t  in_q;
  logic      in_vld_q, in_vld_d;
  bdlp_out_t out_q, res;
  logic      out_vld_q, out_vld_d;
  logic      out_ready, in_ready, step, in_take;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign step      = in_vld_q && out_ready;
  assign in_ready  = !in_vld_q || out_ready;
  assign in_take   = in_vld_i && in_ready;

  assign in_vld_d  = in_take || (in_vld_q && !out_ready);
  assign out_vld_d = step || (out_vld_q && out_stall_i);

  bdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdlp_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign in_stall_o = !in_ready;
  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

  `BDLP_ASSERT_SAME(a_stall_only_when_full, in_stall_o, in_vld_q && out_vld_q && out_stall_i)
  `BDLP_ASSERT_NEXT(a_step_gives_result, step, out_vld_q)
  `BDLP_ASSERT_NEXT(a_no_flag_on_sample_or_clear,
                    step && (in_q.operation == OP_SAMPLE || in_q.operation == OP_CLEAR),
                    !out_q.flag_read)

endmodule

@@ bench/button_debounce_long_press_checker.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press: result checker
// Watches the configuration port and both word channels. Keeps its own copy
// of the debounce state machine and sticky flags, works out the result word
// due for every accepted input word, and compares each accepted result word,
// field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press_checker import bdlp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_vld_i,
  input  logic                in_stall_i,
  input  bdlp_in_t            in_data_i,
  input  logic                out_vld_i,
  input  logic                out_stall_i,
  input  bdlp_out_t           out_data_i,
  output int                  fail_count_o,
  output int                  due_count_o
);

  logic [2:0]       mode;
  logic [TimeW-1:0] change_ms;
  logic             level_now;
  logic             press_seen;
  logic             long_seen;
  logic [LongW-1:0] hold_ms;
  logic [DebW-1:0]  settle_ms;

  bdlp_out_t pending_levels[$];
  bdlp_out_t want;
  int        mismatches;

  function automatic bdlp_out_t debounce_step(bdlp_in_t w);
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] settle_t;
    logic [TimeW-1:0] hold_t;
    logic             taken;
    bdlp_out_t        r;
    held     = w.now_ms - change_ms;
    settle_t = settle_ms;
    hold_t   = hold_ms;
    taken    = 1'b0;
    case (w.operation)
      OP_SAMPLE: begin
        case (mode)
          MODE_IDLE: begin
            if (w.button_down) begin
              mode      = MODE_DEBOUNCE;
              change_ms = w.now_ms;
            end
          end
          MODE_DEBOUNCE: begin
            if (held >= settle_t) begin
              if (w.button_down) begin
                mode       = MODE_PRESSED;
                change_ms  = w.now_ms;
                level_now  = 1'b1;
                press_seen = 1'b1;
              end else begin
                mode = MODE_IDLE;
              end
            end
          end
          MODE_PRESSED: begin
            if (!w.button_down) begin
              mode      = MODE_RELEASED;
              change_ms = w.now_ms;
            end else if (held >= hold_t) begin
              mode      = MODE_LONG;
              change_ms = w.now_ms;
              long_seen = 1'b1;
            end
          end
          MODE_RELEASED: begin
            if (held >= settle_t) begin
              if (!w.button_down) begin
                mode      = MODE_IDLE;
                level_now = 1'b0;
              end else begin
                mode      = MODE_DEBOUNCE;
                change_ms = w.now_ms;
              end
            end
          end
          MODE_LONG: begin
            if (!w.button_down) begin
              mode      = MODE_RELEASED;
              change_ms = w.now_ms;
              level_now = 1'b0;
            end
          end
          default: begin
            mode = MODE_IDLE;
          end
        endcase
      end
      OP_READ_PRESS: begin
        taken      = press_seen;
        press_seen = 1'b0;
      end
      OP_READ_LONG: begin
        taken = long_seen;
        // a long-press read that finds the flag set also drops the press flag
        if (long_seen) begin
          press_seen = 1'b0;
          long_seen  = 1'b0;
        end
      end
      default: begin
        press_seen = 1'b0;
        long_seen  = 1'b0;
      end
    endcase
    r.pressed_level = level_now;
    r.flag_read     = taken;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode       = MODE_IDLE;
      change_ms  = '0;
      level_now  = 1'b0;
      press_seen = 1'b0;
      long_seen  = 1'b0;
      hold_ms    = LONG_PRESS_RST;
      settle_ms  = DEBOUNCE_RST;
      pending_levels.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LONG_PRESS) begin
          hold_ms = cfg_wdata_i[LongW-1:0];
        end else begin
          settle_ms = cfg_wdata_i[DebW-1:0];
        end
      end
      if (in_vld_i && !in_stall_i) begin
        pending_levels.push_back(debounce_step(in_data_i));
      end
      if (out_vld_i && !out_stall_i) begin
        if (pending_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word with none due: level %b flag %b", $realtime,
                     out_data_i.pressed_level, out_data_i.flag_read);
          end
        end else begin
          want = pending_levels.pop_front();
          if (out_data_i.pressed_level !== want.pressed_level ||
              out_data_i.flag_read !== want.flag_read) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: level exp %b got %b, flag exp %b got %b",
                       $realtime, want.pressed_level, out_data_i.pressed_level,
                       want.flag_read, out_data_i.flag_read);
            end
          end
        end
      end
    end
    fail_count_o = mismatches;
    due_count_o  = pending_levels.size();
  end

endmodule

@@ bench/button_debounce_long_press_tb.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press: testbench top
// Drives directed and random sample and flag words through the block under
// several hold and settle times with varying sender gaps and receiver
// stalls; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic                cfg_idx     = 1'b0;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  logic                in_vld      = 1'b0;
  logic                in_stall;
  bdlp_in_t            in_data     = '0;
  logic                out_vld;
  logic                out_stall   = 1'b0;
  bdlp_out_t           out_data;
  logic                in_took     = 1'b0;

  int          err_count;
  int          due;
  int unsigned cycles      = 0;
  int unsigned idle_pct    = 8;
  int unsigned stall_pct   = 76;
  int unsigned long_ms     = LONG_PRESS_RST;
  int unsigned deb_ms      = DEBOUNCE_RST;
  logic [31:0] clock_ms    = '0;
  logic        btn_level   = 1'b0;

  button_debounce_long_press DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_vld_i    (in_vld),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_vld_o   (out_vld),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  button_debounce_long_press_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_vld_i     (in_vld),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_vld_i    (out_vld),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (err_count),
    .due_count_o  (due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    in_took <= in_vld && !in_stall;
    cycles  <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL button_debounce_long_press");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic bdlp_in_t mk(logic [1:0] op, logic down, logic [31:0] now);
    bdlp_in_t w;
    w.operation   = op;
    w.button_down = down;
    w.now_ms      = now;
    return w;
  endfunction

  task automatic send_word(input bdlp_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_vld <= 1'b0;
      @(negedge clk);
    end
    in_vld  <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (!in_took) @(negedge clk);
  endtask

  task automatic wait_results();
    in_vld <= 1'b0;
    @(negedge clk);
    while (due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [LongW-1:0] lp, input logic [CfgDataW-1:0] db);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(negedge clk);
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= db;
    @(negedge clk);
    cfg_we    <= 1'b0;
    long_ms = lp;
    deb_ms  = db[DebW-1:0];
  endtask

  task automatic run_random(input int count);
    bdlp_in_t    w;
    int unsigned pick;
    int unsigned step;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // flag access, sample fields ignored
        case ($urandom_range(2))
          0:       w.operation = OP_READ_PRESS;
          1:       w.operation = OP_READ_LONG;
          default: w.operation = OP_CLEAR;
        endcase
        w.button_down = 1'($urandom);
        w.now_ms      = $urandom;
      end else if (pick < 15) begin
        // stray sample at an arbitrary stamp
        w = mk(OP_SAMPLE, 1'($urandom), $urandom);
      end else begin
        if ($urandom_range(99) < 15) btn_level = !btn_level;
        case ($urandom_range(9))
          7, 8:    step = $urandom_range(long_ms + long_ms / 4 + 1);
          9:       step = 0;
          default: step = $urandom_range(2 * deb_ms + 1);
        endcase
        clock_ms = clock_ms + step;
        w = mk(OP_SAMPLE, btn_level, clock_ms);
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: hold 1000, settle 10
    send_word(mk(OP_SAMPLE, 1'b0, 32'h0000_0000));
    send_word(mk(OP_SAMPLE, 1'b1, 32'hFFFF_FFFA));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd3));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd4));
    send_word(mk(OP_READ_PRESS, 1'b0, 32'hFFFF_FFFF));
    send_word(mk(OP_READ_PRESS, 1'b1, 32'h0000_0000));
    send_word(mk(OP_READ_LONG, 1'($urandom), $urandom));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd1003));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd1004));
    send_word(mk(OP_READ_LONG, 1'($urandom), $urandom));
    send_word(mk(OP_READ_PRESS, 1'($urandom), $urandom));
    send_word(mk(OP_SAMPLE, 1'b0, 32'd1010));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd1015));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd1020));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd1030));
    send_word(mk(OP_SAMPLE, 1'b0, 32'd1031));
    // re-press that bounces back to idle keeps the level set
    send_word(mk(OP_SAMPLE, 1'b1, 32'd1041));
    send_word(mk(OP_SAMPLE, 1'b0, 32'd1051));
    send_word(mk(OP_CLEAR, 1'($urandom), $urandom));
    send_word(mk(OP_READ_PRESS, 1'($urandom), $urandom));

    // zero hold and settle times fire at once
    wait_results();
    write_regs(16'h0000, 16'h0000);
    send_word(mk(OP_SAMPLE, 1'b1, 32'd5));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd5));
    send_word(mk(OP_SAMPLE, 1'b1, 32'd5));
    send_word(mk(OP_READ_LONG, 1'($urandom), $urandom));
    send_word(mk(OP_SAMPLE, 1'b0, 32'd5));
    send_word(mk(OP_SAMPLE, 1'b0, 32'd5));

    wait_results();
    write_regs(16'($urandom_range(300, 20)),
               {8'($urandom_range(255)), 8'($urandom_range(20, 2))});
    run_random(220);

    wait_results();
    idle_pct  = 76;
    stall_pct = 8;
    write_regs(16'hFFFF, 16'hFFFF);
    run_random(220);

    wait_results();
    idle_pct  = 0;
    stall_pct = 0;
    write_regs(16'($urandom_range(2000)), 16'($urandom_range(255)));
    run_random(210);

    wait_results();
    repeat (8) @(negedge clk);
    if (err_count == 0 && due == 0) begin
      $display("PASS button_debounce_long_press");
    end else begin
      $display("FAIL button_debounce_long_press");
    end
    $finish;
  end

endmodule
